/* rtl/spm_pkg.sv */
package spm_pkg;

    localparam int LED_COUNT = 48;

    localparam int LEVEL_W  = 16;
    localparam int OFFSET_W = 14;
    localparam int HOLD_W   = 17;
    localparam int LEDS_W   = 6;
    localparam int DAC_W    = 8;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(256);
    localparam logic [HOLD_W-1:0]   DECAY_RESET  = HOLD_W'(492);
    localparam logic [HOLD_W-1:0]   FULL_Q16     = HOLD_W'(65536);

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [LEDS_W-1:0]         t_leds;
    typedef logic [DAC_W-1:0]          t_dac;
    typedef logic [HOLD_W-1:0]         t_hold;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET = 1'b0,
        CFG_DECAY  = 1'b1
    } t_cfg_idx;

endpackage

/* rtl/spm_in_if.sv */
interface spm_in_if import spm_pkg::*; ();
    logic   valid;
    logic   ready;
    t_level left_level;
    t_level right_level;

    modport source (output valid, output left_level, output right_level, input ready);
    modport sink   (input valid, input left_level, input right_level, output ready);
endinterface

/* rtl/spm_out_if.sv */
interface spm_out_if import spm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_leds left_leds;
    t_leds right_leds;
    t_dac  left_dac;
    t_dac  right_dac;

    modport source (output valid, output left_leds, output right_leds,
                    output left_dac, output right_dac, input ready);
    modport sink   (input valid, input left_leds, input right_leds,
                    input left_dac, input right_dac, output ready);
endinterface

/* rtl/stereo_peak_meter_ballistics.sv */
// Channel   Direction  Handshake            Payload
// i_in      sink       valid/ready          left_level, right_level
// o_out     source     valid/ready          left_leds, right_leds, left_dac, right_dac
// i_cfg_*   write      i_cfg_we             i_cfg_idx, i_cfg_data
//
// Two register stages: an input register, then the result register. The held
// levels update as a transaction moves from the first to the second, so one
// transaction per cycle is sustained while the output is not stalled.
// Synchronous active-low reset clears both valid flags, the held levels and
// loads the register defaults. A stalled output backs up into the input
// register; the input is ready while that register is empty or moving on.
module stereo_peak_meter_ballistics import spm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    spm_in_if.sink               i_in,
    spm_out_if.source            o_out
);

    localparam int SUM_W   = 18;
    localparam int SPAN    = 2048;
    localparam int SPAN_SH = 5;
    localparam int MUL_W   = 25;
    localparam int SCALED_W = MUL_W - 16;

    logic [OFFSET_W-1:0] r_offset;
    t_hold               r_decay;
    t_hold               r_left_hold, r_right_hold;
    t_hold               n_left_hold, n_right_hold;

    logic   r_a_valid;
    t_level r_a_left, r_a_right;

    logic  r_b_valid;
    t_leds r_b_left_leds, r_b_right_leds;
    t_dac  r_b_left_dac, r_b_right_dac;
    t_leds n_left_leds, n_right_leds;
    t_dac  n_left_dac, n_right_dac;

    logic b_load;
    logic a_load;

    function automatic t_hold level_frac(input t_level level, input logic [OFFSET_W-1:0] offs);
        logic signed [SUM_W-1:0] sum;
        logic [HOLD_W-1:0]       res;
        begin
            sum = SUM_W'(level) + $signed({4'b0, offs}) + SUM_W'(SPAN);
            if (sum <= 0) begin
                res = '0;
            end else if (sum >= SUM_W'(SPAN)) begin
                res = FULL_Q16;
            end else begin
                res = HOLD_W'(sum[10:0]) << SPAN_SH;
            end
            return res;
        end
    endfunction

    function automatic t_hold new_hold(input t_hold hold, input t_hold decay, input t_hold frac);
        t_hold fallen;
        begin
            fallen = (hold > decay) ? (hold - decay) : '0;
            return (frac > fallen) ? frac : fallen;
        end
    endfunction

    function automatic logic [SCALED_W-1:0] ceil_scale(input t_hold hold,
                                                        input logic [7:0] mult);
        logic [MUL_W-1:0] prod;
        begin
            prod = MUL_W'(hold) * MUL_W'(mult) + MUL_W'(16'hFFFF);
            return prod[MUL_W-1:16];
        end
    endfunction

    function automatic t_leds led_count(input t_hold hold);
        logic [SCALED_W-1:0] n;
        begin
            n = ceil_scale(hold, 8'(LED_COUNT));
            return (n > SCALED_W'(2**LEDS_W - 1)) ? {LEDS_W{1'b1}} : n[LEDS_W-1:0];
        end
    endfunction

    function automatic t_dac dac_code(input t_hold hold);
        logic [SCALED_W-1:0] n;
        begin
            n = ceil_scale(hold, 8'd255);
            return n[DAC_W-1:0];
        end
    endfunction

    assign b_load = r_a_valid && (!r_b_valid || o_out.ready);
    assign a_load = i_in.valid && i_in.ready;
    assign i_in.ready = !r_a_valid || b_load;

    always_comb begin
        n_left_hold  = new_hold(r_left_hold, r_decay, level_frac(r_a_left, r_offset));
        n_right_hold = new_hold(r_right_hold, r_decay, level_frac(r_a_right, r_offset));
        n_left_leds  = led_count(n_left_hold);
        n_right_leds = led_count(n_right_hold);
        n_left_dac   = dac_code(n_left_hold);
        n_right_dac  = dac_code(n_right_hold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= OFFSET_RESET;
            r_decay      <= DECAY_RESET;
            r_left_hold  <= '0;
            r_right_hold <= '0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                    CFG_DECAY:  r_decay  <= i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (a_load) begin
                r_a_valid <= 1'b1;
            end else if (b_load) begin
                r_a_valid <= 1'b0;
            end
            if (b_load) begin
                r_b_valid    <= 1'b1;
                r_left_hold  <= n_left_hold;
                r_right_hold <= n_right_hold;
            end else if (o_out.ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_left  <= i_in.left_level;
            r_a_right <= i_in.right_level;
        end
        if (b_load) begin
            r_b_left_leds  <= n_left_leds;
            r_b_right_leds <= n_right_leds;
            r_b_left_dac   <= n_left_dac;
            r_b_right_dac  <= n_right_dac;
        end
    end

    assign o_out.valid      = r_b_valid;
    assign o_out.left_leds  = r_b_left_leds;
    assign o_out.right_leds = r_b_right_leds;
    assign o_out.left_dac   = r_b_left_dac;
    assign o_out.right_dac  = r_b_right_dac;

endmodule
